[hw/rtl/chd_pkg.sv]
// shared types and codes of the canonical huffman decoder
`timescale 1ns / 1ps
package chd_pkg;

   // request operations
   localparam logic [1:0] OP_LOAD_COUNT  = 2'd0;
   localparam logic [1:0] OP_LOAD_SYMBOL = 2'd1;
   localparam logic [1:0] OP_DECODE      = 2'd2;

   // kinds of job passed from front to back
   localparam logic [1:0] JOB_WRITE  = 2'd0;
   localparam logic [1:0] JOB_LOOKUP = 2'd1;
   localparam logic [1:0] JOB_ERROR  = 2'd2;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] index;
      logic [7:0] value;
      logic       code_bit;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [4:0] code_length;
      logic [7:0] value;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

[hw/rtl/chd_if.sv]
// valid/ready channel interfaces for requests and responses
`timescale 1ns / 1ps
interface chd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] index;
   logic [7:0] value;
   logic       code_bit;

   modport source (output valid, op, index, value, code_bit, input ready);
   modport sink (input valid, op, index, value, code_bit, output ready);
endinterface

interface chd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic [4:0] code_length;
   logic       error;

   modport source (output valid, symbol, code_length, error, input ready);
   modport sink (input valid, symbol, code_length, error, output ready);
endinterface

[hw/rtl/chd_front.sv]
// front end: length counts, bit-serial canonical decode, job generation
`timescale 1ns / 1ps
module chd_front #(
   parameter int MAX_CODE_LENGTH = 16,
   parameter int SYMBOL_SLOTS = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  chd_pkg::req_type                req,
   output logic                            push_valid,
   output chd_pkg::job_type                push_job,
   output logic [$clog2(SYMBOL_SLOTS)-1:0] push_pos
);

   localparam int IW = $clog2(MAX_CODE_LENGTH);
   localparam int LW = $clog2(MAX_CODE_LENGTH + 1);
   localparam int SW = $clog2(SYMBOL_SLOTS);
   localparam int FW = MAX_CODE_LENGTH + 1;
   localparam int DW = MAX_CODE_LENGTH + 10;
   localparam int MW = SW + 9;
   localparam logic [DW-1:0] FIRST_CAP = DW'(1) << MAX_CODE_LENGTH;

   // restoring reduction, input stays below 32 * SYMBOL_SLOTS
   function automatic logic [SW-1:0] wrap_slot(input logic [MW-1:0] x);
      logic [MW-1:0] r;
      r = x;
      for (int k = 4; k >= 0; k--) begin
         if (r >= (MW'(SYMBOL_SLOTS) << k)) begin
            r = r - (MW'(SYMBOL_SLOTS) << k);
         end
      end
      return r[SW-1:0];
   endfunction

   logic [7:0]                 counts_ff [MAX_CODE_LENGTH];
   logic [MAX_CODE_LENGTH-1:0] partial_ff, partial_in;
   logic [IW-1:0]              bits_ff, bits_in;
   logic [FW-1:0]              first_ff, first_in;
   logic [SW-1:0]              base_ff, base_in;

   logic [7:0]                 count;
   logic [MAX_CODE_LENGTH-1:0] partial_new;
   logic [DW-1:0]              partial_ext, first_ext, diff, first_sum;
   logic [LW-1:0]              len_new;
   logic                       hit, last, is_decode, count_wr;

   always_comb begin
      count       = counts_ff[bits_ff];
      partial_new = {partial_ff[MAX_CODE_LENGTH-2:0], req.code_bit};
      partial_ext = DW'(partial_new);
      first_ext   = DW'(first_ff);
      diff        = partial_ext - first_ext;
      hit         = (partial_ext >= first_ext) && (diff < DW'(count));
      last        = (bits_ff == IW'(MAX_CODE_LENGTH - 1));
      len_new     = LW'(bits_ff) + LW'(1);
      // first code beyond the code space never matches again, so it saturates
      first_sum   = (first_ext + DW'(count)) << 1;
      is_decode   = accept && (req.op == chd_pkg::OP_DECODE);
      count_wr    = accept && (req.op == chd_pkg::OP_LOAD_COUNT)
                    && (int'(req.index) < MAX_CODE_LENGTH);

      partial_in = partial_ff;
      bits_in    = bits_ff;
      first_in   = first_ff;
      base_in    = base_ff;
      if (is_decode) begin
         if (hit || last) begin
            partial_in = '0;
            bits_in    = '0;
            first_in   = '0;
            base_in    = '0;
         end else begin
            partial_in = partial_new;
            bits_in    = bits_ff + IW'(1);
            first_in   = (first_sum > FIRST_CAP) ? FW'(FIRST_CAP) : FW'(first_sum);
            base_in    = wrap_slot(MW'(base_ff) + MW'(count));
         end
      end

      push_valid           = 1'b0;
      push_job.kind        = chd_pkg::JOB_WRITE;
      push_job.code_length = '0;
      push_job.value       = req.value;
      push_pos             = wrap_slot(MW'(req.index));
      if (accept && (req.op == chd_pkg::OP_LOAD_SYMBOL)) begin
         push_valid = 1'b1;
      end else if (is_decode && hit) begin
         push_valid           = 1'b1;
         push_job.kind        = chd_pkg::JOB_LOOKUP;
         push_job.code_length = 5'(len_new);
         push_pos             = wrap_slot(MW'(base_ff) + MW'(diff[7:0]));
      end else if (is_decode && last) begin
         push_valid    = 1'b1;
         push_job.kind = chd_pkg::JOB_ERROR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         bits_ff    <= '0;
         first_ff   <= '0;
         base_ff    <= '0;
         for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         partial_ff <= partial_in;
         bits_ff    <= bits_in;
         first_ff   <= first_in;
         base_ff    <= base_in;
         if (count_wr) begin
            counts_ff[req.index[IW-1:0]] <= req.value;
         end
      end
   end

endmodule

[hw/rtl/chd_fifo.sv]
// small job queue between front and back
`timescale 1ns / 1ps
module chd_fifo #(
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [WIDTH-1:0]         push_data,
   input  logic                     pop,
   output logic [WIDTH-1:0]         pop_data,
   output chd_pkg::fifo_status_type status
);

   localparam int PW = $clog2(chd_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(chd_pkg::QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slots_ff [chd_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      status.full  = (count_ff == CW'(chd_pkg::QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      pop_data     = slots_ff[rd_ptr_ff];
      wr_ptr_in    = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in    = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in     = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/chd_back.sv]
// back end: symbol memory and registered response
`timescale 1ns / 1ps
module chd_back #(
   parameter int SYMBOL_SLOTS = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_empty,
   input  chd_pkg::job_type                q_job,
   input  logic [$clog2(SYMBOL_SLOTS)-1:0] q_pos,
   output logic                            pop,
   input  logic                            out_ready,
   output logic                            out_valid,
   output logic [7:0]                      out_symbol,
   output logic [4:0]                      out_code_length,
   output logic                            out_error
);

   logic [7:0] sym_mem [SYMBOL_SLOTS];
   logic [7:0] rdata_ff;
   logic       valid_ff, valid_in;
   logic [4:0] len_ff;
   logic       err_ff;
   logic       is_write, take_result;

   always_comb begin
      is_write    = (q_job.kind == chd_pkg::JOB_WRITE);
      // writes retire at once, results wait for a free output register
      pop         = !q_empty && (is_write || !valid_ff || out_ready);
      take_result = pop && !is_write;
      if (take_result) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
      out_valid       = valid_ff;
      out_symbol      = err_ff ? 8'd0 : rdata_ff;
      out_code_length = len_ff;
      out_error       = err_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_result) begin
         len_ff <= q_job.code_length;
         err_ff <= (q_job.kind == chd_pkg::JOB_ERROR);
      end
   end

   always_ff @(posedge clock) begin
      if (pop && is_write) begin
         sym_mem[q_pos] <= q_job.value;
      end
      if (take_result) begin
         rdata_ff <= sym_mem[q_pos];
      end
   end

endmodule

[hw/rtl/canonical_huffman_decoder_top.sv]
// Canonical Huffman decoder, bit-serial, JPEG-style tables.
// The req channel carries load-count, load-symbol and decode-bit items; the
// rsp channel returns one item per finished code: symbol, code length, and
// an error flag when sixteen (MAX_CODE_LENGTH) bits arrive without a match.
// Both channels are valid/ready; an item moves when valid and ready are high.
// Throughput is one item per cycle while the queue is not full: the front
// takes one code bit per cycle, one compare and one add against the
// per-length first code and symbol base. The job for the bit that ends a
// code enters the queue when the bit is accepted; the registered read of the
// symbol memory then fills the rsp.valid register once that is free.
// Symbol loads travel through the same queue, so they stay in order with
// lookups. A stalled rsp fills the four-entry queue, after which req.ready
// drops; the front never stalls otherwise.
// Synchronous reset clears the length counts, the decode progress, the queue
// and the response valid bit; the symbol memory keeps no reset and must be
// loaded before use.
`timescale 1ns / 1ps
module canonical_huffman_decoder_top #(
   parameter int MAX_CODE_LENGTH = 16,
   parameter int SYMBOL_SLOTS = 256
) (
   input logic      clock,
   input logic      reset,
   chd_req_if.sink  req,
   chd_rsp_if.source rsp
);

   localparam int SW = $clog2(SYMBOL_SLOTS);
   localparam int JW = $bits(chd_pkg::job_type) + SW;

   chd_pkg::req_type         req_item;
   chd_pkg::job_type         push_job, q_job;
   chd_pkg::fifo_status_type q_status;
   logic [SW-1:0]            push_pos, q_pos;
   logic                     accept, push_valid, pop;

   assign req_item = '{op: req.op, index: req.index, value: req.value,
                       code_bit: req.code_bit};
   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;

   chd_front #(
      .MAX_CODE_LENGTH(MAX_CODE_LENGTH),
      .SYMBOL_SLOTS(SYMBOL_SLOTS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .req(req_item),
      .push_valid(push_valid),
      .push_job(push_job),
      .push_pos(push_pos)
   );

   chd_fifo #(
      .WIDTH(JW)
   ) u_fifo (
      .clock(clock),
      .reset(reset),
      .push(push_valid),
      .push_data({push_job, push_pos}),
      .pop(pop),
      .pop_data({q_job, q_pos}),
      .status(q_status)
   );

   chd_back #(
      .SYMBOL_SLOTS(SYMBOL_SLOTS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_empty(q_status.empty),
      .q_job(q_job),
      .q_pos(q_pos),
      .pop(pop),
      .out_ready(rsp.ready),
      .out_valid(rsp.valid),
      .out_symbol(rsp.symbol),
      .out_code_length(rsp.code_length),
      .out_error(rsp.error)
   );

   // the queue is never pushed when full
   assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !q_status.full)
      else $error("job pushed into full queue");

   // a pushed job is waiting in the queue in the cycle after the push
   assert property (@(posedge clock) disable iff (reset)
      push_valid |=> !q_status.empty)
      else $error("pushed job lost");

   // nothing is popped from an empty queue
   assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");

   // an error response carries no symbol and no length
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.error) |-> (rsp.symbol == 8'd0 && rsp.code_length == 5'd0))
      else $error("error response with payload");

endmodule

[tb/sv/tb.sv]
// self-checking testbench for the canonical huffman decoder
`timescale 1ns / 1ps
module tb;

   localparam logic [1:0] OP_UNDEFINED = 2'd3;
   localparam int CODE_MAX = 16;
   localparam int SLOT_COUNT = 256;
   localparam int ITEM_TARGET = 450;
   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic [7:0] symbol;
      logic [4:0] code_length;
      logic       error;
   } sym_result_type;

   typedef struct {
      chd_pkg::req_type payload;
      bit               drain;
   } req_entry_type;

   logic clock = 1'b0;
   logic reset;

   chd_req_if req_bus ();
   chd_rsp_if rsp_bus ();

   canonical_huffman_decoder_top dut (
      .clock(clock),
      .reset(reset),
      .req(req_bus),
      .rsp(rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // pending request items and decoded symbols still owed by the block
   req_entry_type  req_backlog[$];
   sym_result_type symbol_due[$];

   // shadow of the decoder state
   logic [7:0]  count_tab[CODE_MAX];
   logic [7:0]  sym_mem[SLOT_COUNT];
   logic [63:0] acc_code;
   logic [63:0] first_code;
   logic [7:0]  base_pos;
   int unsigned bits_seen;

   // table as the stimulus side believes it to be
   int unsigned gen_counts[CODE_MAX];
   int unsigned gen_total;

   int unsigned accepted = 0;
   int unsigned drains = 0;
   int unsigned tables = 0;
   int unsigned mismatches = 0;
   int unsigned n_symbols = 0;
   int unsigned n_errors = 0;
   int unsigned n_long = 0;

   req_entry_type  in_flight;
   bit             src_busy;
   bit             src_go;
   int unsigned    src_gap = 0;
   int unsigned    src_calm = 0;
   int unsigned    sink_hold = 0;
   int unsigned    sink_calm = 0;
   int unsigned    idle_cycles = 0;
   sym_result_type want;

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
   endtask

   function automatic int unsigned idle_len(inout int unsigned calm);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      // now and then a stretch with no idling at all
      if (roll < 3) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic restart_code();
      acc_code = '0;
      first_code = '0;
      base_pos = '0;
      bits_seen = 0;
   endtask

   task automatic huffman_predict(input chd_pkg::req_type it);
      logic [63:0] cnt;
      logic [63:0] off;
      logic [7:0]  slot;
      sym_result_type r;
      case (it.op)
         chd_pkg::OP_LOAD_COUNT: begin
            if (it.index < CODE_MAX) count_tab[it.index[3:0]] = it.value;
         end
         chd_pkg::OP_LOAD_SYMBOL: begin
            sym_mem[it.index] = it.value;
         end
         chd_pkg::OP_DECODE: begin
            acc_code = {acc_code[62:0], it.code_bit};
            bits_seen++;
            cnt = 64'(count_tab[4'(bits_seen - 1)]);
            if (acc_code >= first_code && acc_code - first_code < cnt) begin
               off = acc_code - first_code;
               slot = base_pos + off[7:0];
               r.symbol = sym_mem[slot];
               r.code_length = 5'(bits_seen);
               r.error = 1'b0;
               symbol_due.push_back(r);
               restart_code();
            end else if (bits_seen >= CODE_MAX) begin
               r.symbol = '0;
               r.code_length = '0;
               r.error = 1'b1;
               symbol_due.push_back(r);
               restart_code();
            end else begin
               base_pos = base_pos + cnt[7:0];
               first_code = (first_code + cnt) << 1;
            end
         end
         default: ;
      endcase
   endtask

   task automatic post_req(input logic [1:0] op, input logic [7:0] idx, input logic [7:0] val,
                           input logic cbit, input bit drain);
      req_entry_type e;
      e.payload.op = op;
      e.payload.index = idx;
      e.payload.value = val;
      e.payload.code_bit = cbit;
      e.drain = drain;
      req_backlog.push_back(e);
   endtask

   task automatic post_bit(input logic b);
      post_req(chd_pkg::OP_DECODE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               b, 1'b0);
   endtask

   // random canonical table, sometimes deliberately overfull
   task automatic pick_table(input bit drain);
      int unsigned avail;
      int unsigned top;
      int unsigned lim;
      bit overfull;
      top = $urandom_range(1, CODE_MAX);
      overfull = ($urandom_range(0, 5) == 0);
      avail = 2;
      gen_total = 0;
      tables++;
      for (int l = 0; l < CODE_MAX; l++) begin
         if (overfull)
            gen_counts[l] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 0;
         else if (l + 1 > top)
            gen_counts[l] = 0;
         else if (l + 1 == top && avail <= 12)
            gen_counts[l] = avail;
         else
            gen_counts[l] = $urandom_range(0, avail < 4 ? avail : 4);
         if (!overfull) avail = (avail - gen_counts[l]) * 2;
         gen_total += gen_counts[l];
         post_req(chd_pkg::OP_LOAD_COUNT, 8'(l), 8'(gen_counts[l]),
                  1'($urandom_range(0, 1)), drain && l == 0);
      end
      lim = gen_total < 32 ? gen_total : 32;
      for (int p = 0; p < lim; p++)
         post_req(chd_pkg::OP_LOAD_SYMBOL, 8'(p), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'b0);
   endtask

   // bits of the canonical code at a symbol position, msb first
   task automatic send_code(input int unsigned pos);
      int unsigned f;
      int unsigned b;
      int unsigned c;
      int unsigned code;
      int unsigned len;
      f = 0;
      b = 0;
      code = 0;
      len = 0;
      for (int l = 1; l <= CODE_MAX && len == 0; l++) begin
         c = gen_counts[l - 1];
         if (pos < b + c) begin
            code = f + pos - b;
            len = l;
         end else begin
            b += c;
            f = (f + c) << 1;
         end
      end
      for (int k = int'(len) - 1; k >= 0; k--) post_bit(1'((code >> k) & 1));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         src_gap = 0;
      end else begin
         src_busy = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            huffman_predict(in_flight.payload);
            accepted++;
            src_busy = 1'b0;
         end
         if (!src_busy) begin
            src_go = 1'b0;
            if (src_gap > 0) begin
               src_gap--;
            end else if (req_backlog.size() != 0 &&
                         !(req_backlog[0].drain && symbol_due.size() != 0)) begin
               in_flight = req_backlog.pop_front();
               req_bus.op <= in_flight.payload.op;
               req_bus.index <= in_flight.payload.index;
               req_bus.value <= in_flight.payload.value;
               req_bus.code_bit <= in_flight.payload.code_bit;
               src_go = 1'b1;
               src_gap = idle_len(src_calm);
               if (in_flight.drain) drains++;
            end
            req_bus.valid <= src_go;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         sink_hold = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (symbol_due.size() == 0) begin
               flag_mismatch($sformatf("unexpected item sym=%0h len=%0d err=%0b",
                                       rsp_bus.symbol, rsp_bus.code_length, rsp_bus.error));
            end else begin
               want = symbol_due.pop_front();
               if (rsp_bus.symbol !== want.symbol)
                  flag_mismatch($sformatf("symbol %0h, expected %0h",
                                          rsp_bus.symbol, want.symbol));
               if (rsp_bus.code_length !== want.code_length)
                  flag_mismatch($sformatf("code_length %0d, expected %0d",
                                          rsp_bus.code_length, want.code_length));
               if (rsp_bus.error !== want.error)
                  flag_mismatch($sformatf("error %0b, expected %0b",
                                          rsp_bus.error, want.error));
               if (want.error) n_errors++;
               else n_symbols++;
               if (want.code_length == 5'(CODE_MAX)) n_long++;
            end
         end
         if (sink_hold > 0) begin
            sink_hold--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            sink_hold = idle_len(sink_calm);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("no handshake for %0d cycles, %0d items still owed",
                     idle_cycles, symbol_due.size());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      int unsigned ncodes;
      int unsigned sel;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.op = chd_pkg::OP_LOAD_COUNT;
      req_bus.index = '0;
      req_bus.value = '0;
      req_bus.code_bit = 1'b0;
      rsp_bus.ready = 1'b0;
      for (int l = 0; l < CODE_MAX; l++) count_tab[l] = '0;
      for (int p = 0; p < SLOT_COUNT; p++) sym_mem[p] = '0;
      restart_code();

      // every symbol slot gets written before anything is decoded
      for (int p = 0; p < SLOT_COUNT; p++)
         post_req(chd_pkg::OP_LOAD_SYMBOL, 8'(p), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'b0);

      post_req(OP_UNDEFINED, 8'hFF, 8'hFF, 1'b1, 1'b0);
      post_req(chd_pkg::OP_LOAD_COUNT, 8'hFF, 8'hFF, 1'b1, 1'b0);
      // 255 one-bit codes: far more than the code space holds
      post_req(chd_pkg::OP_LOAD_COUNT, 8'd0, 8'hFF, 1'b0, 1'b0);
      post_req(chd_pkg::OP_LOAD_SYMBOL, 8'd1, 8'hFF, 1'b0, 1'b0);
      post_req(chd_pkg::OP_LOAD_SYMBOL, 8'd0, 8'h00, 1'b0, 1'b0);
      post_bit(1'b1);
      post_bit(1'b0);
      // count change between the two bits of one code
      post_req(chd_pkg::OP_LOAD_COUNT, 8'd0, 8'h00, 1'b0, 1'b0);
      post_bit(1'b1);
      post_req(chd_pkg::OP_LOAD_COUNT, 8'd1, 8'hFF, 1'b0, 1'b0);
      post_bit(1'b0);
      // sixteen-bit code whose symbol position wraps past the last slot
      post_req(chd_pkg::OP_LOAD_COUNT, 8'd1, 8'h00, 1'b0, 1'b0);
      post_req(chd_pkg::OP_LOAD_COUNT, 8'd14, 8'hFF, 1'b0, 1'b0);
      post_req(chd_pkg::OP_LOAD_COUNT, 8'd15, 8'hFF, 1'b0, 1'b0);
      repeat (7) post_bit(1'b0);
      repeat (9) post_bit(1'b1);

      while (req_backlog.size() < ITEM_TARGET) begin
         pick_table(tables % 2 == 0);
         ncodes = $urandom_range(8, 24);
         for (int k = 0; k < ncodes && req_backlog.size() < ITEM_TARGET; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 75 && gen_total > 0)
               send_code($urandom_range(0, gen_total - 1));
            else if (sel < 85)
               repeat ($urandom_range(1, 20)) post_bit(1'($urandom_range(0, 1)));
            else if (sel < 88)
               repeat (CODE_MAX) post_bit(1'b1);
            else if (sel < 92)
               post_req(chd_pkg::OP_LOAD_COUNT, 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
            else if (sel < 96)
               post_req(chd_pkg::OP_LOAD_SYMBOL, 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
            else
               post_req(OP_UNDEFINED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), 1'b0);
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_bus.valid) @(posedge clock);
      while (symbol_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d request items over %0d random tables, %0d drained pauses",
               accepted, tables, drains);
      $display("checked %0d symbols, %0d no-match errors, %0d sixteen-bit codes, %0d mismatches",
               n_symbols, n_errors, n_long, mismatches);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/chd_pkg.sv
hw/rtl/chd_if.sv
hw/rtl/chd_front.sv
hw/rtl/chd_fifo.sv
hw/rtl/chd_back.sv
hw/rtl/canonical_huffman_decoder_top.sv
tb/sv/tb.sv
